// File: design/cdd_pkg.sv
package cdd_pkg;

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_MIN_DWELL   = 2'd0;
    localparam t_cfg_idx REG_MAX_DWELL   = 2'd1;
    localparam t_cfg_idx REG_MOVE_THRESH = 2'd2;

    localparam int MIN_DWELL_RST   = 300;
    localparam int MAX_DWELL_RST   = 3000;
    localparam int MOVE_THRESH_RST = 1311;

    // Front sequencer
    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_DIST = 5'b00010,
        F_UPD  = 5'b00100,
        F_LOAD = 5'b01000,
        F_PUSH = 5'b10000
    } t_front_state;

    // Back divider sequencer
    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_DIV  = 2'b10
    } t_back_state;

endpackage

// File: design/cdd_sample_if.sv
interface cdd_sample_if #(
    parameter int TIME_BITS  = 31,
    parameter int COORD_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [TIME_BITS-1:0]  time_ms;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic                  last_sample;

    modport source (output valid, time_ms, pos_x, pos_y, last_sample, input ready);
    modport sink   (input valid, time_ms, pos_x, pos_y, last_sample, output ready);
endinterface

// File: design/cdd_result_if.sv
interface cdd_result_if #(
    parameter int TIME_BITS  = 31,
    parameter int COORD_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [TIME_BITS-1:0]  center_time_ms;
    logic [COORD_BITS-1:0] focus_x;
    logic [COORD_BITS-1:0] focus_y;
    logic [TIME_BITS-1:0]  dwell_duration_ms;

    modport source (output valid, center_time_ms, focus_x, focus_y, dwell_duration_ms,
                    input ready);
    modport sink   (input valid, center_time_ms, focus_x, focus_y, dwell_duration_ms,
                    output ready);
endinterface

// File: design/cdd_queue.sv
module cdd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// File: design/cdd_front.sv
module cdd_front import cdd_pkg::*; #(
    parameter int TIME_BITS      = 31,
    parameter int COORD_BITS     = 16,
    parameter int RUN_COUNT_BITS = 32,
    parameter int CFG_W          = 31,
    localparam int SUM_W = RUN_COUNT_BITS + COORD_BITS,
    localparam int JOB_W = 2 * TIME_BITS + RUN_COUNT_BITS + 2 * SUM_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    cdd_sample_if.sink       i_sample,
    output logic             o_push_valid,
    input  logic             i_push_ready,
    output logic [JOB_W-1:0] o_push_data
);

    t_front_state r_state;

    logic [TIME_BITS-1:0]      r_min_dwell;
    logic [TIME_BITS-1:0]      r_max_dwell;
    logic [COORD_BITS-1:0]     r_move_thresh;

    // sample under work
    logic [TIME_BITS-1:0]      r_t;
    logic [COORD_BITS-1:0]     r_x;
    logic [COORD_BITS-1:0]     r_y;
    logic                      r_last;

    // run state
    logic                      r_have_prev;
    logic [COORD_BITS-1:0]     r_prev_x;
    logic [COORD_BITS-1:0]     r_prev_y;
    logic [TIME_BITS-1:0]      r_prev_t;
    logic [TIME_BITS-1:0]      r_start_t;
    logic [RUN_COUNT_BITS-1:0] r_cnt;
    logic [SUM_W-1:0]          r_sum_x;
    logic [SUM_W-1:0]          r_sum_y;

    // distance stage
    logic [2*COORD_BITS-1:0]   r_dx2;
    logic [2*COORD_BITS-1:0]   r_dy2;
    logic [2*COORD_BITS-1:0]   r_th2;
    logic                      r_brk;

    // closed run waiting for the qualification check
    logic [TIME_BITS-1:0]      r_job_s;
    logic [TIME_BITS-1:0]      r_job_e;
    logic [RUN_COUNT_BITS-1:0] r_job_n;
    logic [SUM_W-1:0]          r_job_sx;
    logic [SUM_W-1:0]          r_job_sy;

    logic [COORD_BITS-1:0]     dx;
    logic [COORD_BITS-1:0]     dy;
    logic [2*COORD_BITS-1:0]   dx_sq;
    logic [2*COORD_BITS-1:0]   dy_sq;
    logic [2*COORD_BITS-1:0]   th_sq;
    logic [2*COORD_BITS:0]     d2;
    logic                      brk;
    logic [RUN_COUNT_BITS-1:0] cnt_inc;
    logic [TIME_BITS-1:0]      dur;
    logic                      qualify;
    logic                      push_done;

    assign dx    = (r_x >= r_prev_x) ? r_x - r_prev_x : r_prev_x - r_x;
    assign dy    = (r_y >= r_prev_y) ? r_y - r_prev_y : r_prev_y - r_y;
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;
    assign th_sq = r_move_thresh * r_move_thresh;
    assign d2    = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign brk   = r_have_prev && (d2 > {1'b0, r_th2});
    assign cnt_inc = r_cnt + 1'b1;

    assign dur     = r_job_e - r_job_s;
    assign qualify = (r_brk || r_last)
                  && (r_job_n >= RUN_COUNT_BITS'(2))
                  && (r_job_n != '1)
                  && (r_job_e >= r_job_s)
                  && (dur >= r_min_dwell)
                  && (dur <= r_max_dwell);

    assign push_done = !qualify || i_push_ready;

    assign i_sample.ready = (r_state == F_IDLE);
    assign o_push_valid   = (r_state == F_PUSH) && qualify;
    assign o_push_data    = {r_job_s, r_job_e, r_job_n, r_job_sx, r_job_sy};

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= F_IDLE;
            r_have_prev   <= 1'b0;
            r_cnt         <= '0;
            r_min_dwell   <= TIME_BITS'(MIN_DWELL_RST);
            r_max_dwell   <= TIME_BITS'(MAX_DWELL_RST);
            r_move_thresh <= COORD_BITS'(MOVE_THRESH_RST);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MIN_DWELL:   r_min_dwell   <= i_cfg_data[TIME_BITS-1:0];
                    REG_MAX_DWELL:   r_max_dwell   <= i_cfg_data[TIME_BITS-1:0];
                    REG_MOVE_THRESH: r_move_thresh <= i_cfg_data[COORD_BITS-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                F_IDLE: begin
                    if (i_sample.valid) begin
                        r_state <= F_DIST;
                    end
                end
                F_DIST: begin
                    r_state <= F_UPD;
                end
                F_UPD: begin
                    r_have_prev <= 1'b1;
                    if (!r_have_prev || brk) begin
                        r_cnt <= RUN_COUNT_BITS'(1);
                    end else if (r_cnt != '1) begin
                        r_cnt <= cnt_inc;
                    end
                    if (brk) begin
                        r_state <= F_PUSH;
                    end else if (r_last) begin
                        r_state <= F_LOAD;
                    end else begin
                        r_state <= F_IDLE;
                    end
                end
                F_LOAD: begin
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (push_done) begin
                        if (r_last) begin
                            r_have_prev <= 1'b0;
                            r_cnt       <= '0;
                        end
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (i_sample.valid) begin
                    r_t    <= i_sample.time_ms;
                    r_x    <= i_sample.pos_x;
                    r_y    <= i_sample.pos_y;
                    r_last <= i_sample.last_sample;
                end
            end
            F_DIST: begin
                r_dx2 <= dx_sq;
                r_dy2 <= dy_sq;
                r_th2 <= th_sq;
            end
            F_UPD: begin
                r_brk <= brk;
                if (brk) begin
                    // close the old run at the previous sample
                    r_job_s  <= r_start_t;
                    r_job_e  <= r_prev_t;
                    r_job_n  <= r_cnt;
                    r_job_sx <= r_sum_x;
                    r_job_sy <= r_sum_y;
                end
                if (!r_have_prev || brk) begin
                    r_start_t <= r_t;
                    r_sum_x   <= SUM_W'(r_x);
                    r_sum_y   <= SUM_W'(r_y);
                end else if (r_cnt != '1 && cnt_inc != '1) begin
                    r_sum_x <= r_sum_x + SUM_W'(r_x);
                    r_sum_y <= r_sum_y + SUM_W'(r_y);
                end
                r_prev_x <= r_x;
                r_prev_y <= r_y;
                r_prev_t <= r_t;
            end
            F_LOAD: begin
                // flush: close the updated run at this sample
                r_job_s  <= r_start_t;
                r_job_e  <= r_t;
                r_job_n  <= r_cnt;
                r_job_sx <= r_sum_x;
                r_job_sy <= r_sum_y;
            end
            default: ;
        endcase
    end

endmodule

// File: design/cdd_back.sv
module cdd_back import cdd_pkg::*; #(
    parameter int TIME_BITS      = 31,
    parameter int COORD_BITS     = 16,
    parameter int RUN_COUNT_BITS = 32,
    localparam int SUM_W  = RUN_COUNT_BITS + COORD_BITS,
    localparam int JOB_W  = 2 * TIME_BITS + RUN_COUNT_BITS + 2 * SUM_W,
    localparam int STEP_W = $clog2(COORD_BITS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pop_valid,
    output logic             o_pop_ready,
    input  logic [JOB_W-1:0] i_pop_data,
    cdd_result_if.source     o_result
);

    t_back_state r_state;

    logic [STEP_W-1:0]         r_step;
    logic [RUN_COUNT_BITS-1:0] r_n;
    logic [RUN_COUNT_BITS-1:0] r_rem_x;
    logic [RUN_COUNT_BITS-1:0] r_rem_y;
    logic [COORD_BITS-1:0]     r_q_x;
    logic [COORD_BITS-1:0]     r_q_y;
    logic [TIME_BITS-1:0]      r_center;
    logic [TIME_BITS-1:0]      r_dur;

    logic                      r_out_valid;
    logic [TIME_BITS-1:0]      r_out_center;
    logic [COORD_BITS-1:0]     r_out_fx;
    logic [COORD_BITS-1:0]     r_out_fy;
    logic [TIME_BITS-1:0]      r_out_dur;

    logic [TIME_BITS-1:0]      job_s;
    logic [TIME_BITS-1:0]      job_e;
    logic [RUN_COUNT_BITS-1:0] job_n;
    logic [SUM_W-1:0]          job_sx;
    logic [SUM_W-1:0]          job_sy;
    logic [SUM_W-1:0]          dvd_x;
    logic [SUM_W-1:0]          dvd_y;
    logic [TIME_BITS-1:0]      center;
    logic [RUN_COUNT_BITS:0]   rem2_x;
    logic [RUN_COUNT_BITS:0]   rem2_y;
    logic [RUN_COUNT_BITS:0]   n_ext;
    logic                      ge_x;
    logic                      ge_y;
    logic                      pop;
    logic                      div_done;
    logic                      out_free;
    logic                      load_out;

    assign {job_s, job_e, job_n, job_sx, job_sy} = i_pop_data;

    // round to nearest: add half the divisor before dividing
    assign dvd_x  = job_sx + SUM_W'(job_n >> 1);
    assign dvd_y  = job_sy + SUM_W'(job_n >> 1);
    // half-up midpoint without overflow
    assign center = TIME_BITS'({1'b0, job_s[TIME_BITS-1:1]} + {1'b0, job_e[TIME_BITS-1:1]}
                  + TIME_BITS'(job_s[0] | job_e[0]));

    assign n_ext  = {1'b0, r_n};
    assign rem2_x = {r_rem_x, r_q_x[COORD_BITS-1]};
    assign rem2_y = {r_rem_y, r_q_y[COORD_BITS-1]};
    assign ge_x   = rem2_x >= n_ext;
    assign ge_y   = rem2_y >= n_ext;

    assign o_pop_ready = (r_state == B_IDLE);
    assign pop         = i_pop_valid && o_pop_ready;
    assign div_done    = (r_step == STEP_W'(COORD_BITS));
    assign out_free    = !r_out_valid || o_result.ready;
    assign load_out    = (r_state == B_DIV) && div_done && out_free;

    assign o_result.valid             = r_out_valid;
    assign o_result.center_time_ms    = r_out_center;
    assign o_result.focus_x           = r_out_fx;
    assign o_result.focus_y           = r_out_fy;
    assign o_result.dwell_duration_ms = r_out_dur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (pop) begin
                        r_state <= B_DIV;
                    end
                end
                B_DIV: begin
                    if (load_out) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // restoring division, one quotient bit per cycle for x and y side by side
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_step   <= '0;
            r_n      <= job_n;
            r_rem_x  <= dvd_x[SUM_W-1:COORD_BITS];
            r_rem_y  <= dvd_y[SUM_W-1:COORD_BITS];
            r_q_x    <= dvd_x[COORD_BITS-1:0];
            r_q_y    <= dvd_y[COORD_BITS-1:0];
            r_center <= center;
            r_dur    <= job_e - job_s;
        end else if (r_state == B_DIV && !div_done) begin
            r_step  <= r_step + 1'b1;
            r_rem_x <= ge_x ? RUN_COUNT_BITS'(rem2_x - n_ext) : rem2_x[RUN_COUNT_BITS-1:0];
            r_rem_y <= ge_y ? RUN_COUNT_BITS'(rem2_y - n_ext) : rem2_y[RUN_COUNT_BITS-1:0];
            r_q_x   <= {r_q_x[COORD_BITS-2:0], ge_x};
            r_q_y   <= {r_q_y[COORD_BITS-2:0], ge_y};
        end
        if (load_out) begin
            r_out_center <= r_center;
            r_out_fx     <= r_q_x;
            r_out_fy     <= r_q_y;
            r_out_dur    <= r_dur;
        end
    end

endmodule

// File: design/cursor_dwell_detector.sv
// Dwell detector for a time-ordered cursor stream. Each sample transfer on i_sample
// carries a time stamp in ms and an unsigned Q0.16 position. A step longer than
// move_threshold (squared distance against squared threshold, exact) closes the
// current run and opens a new one; last_sample closes the current run and clears the
// run state (registers keep their values). A closed run gives one transfer on
// o_result when it holds at least two samples, its end time is not below its start,
// and its duration lies within [min_dwell_ms, max_dwell_ms]: center time rounded
// half up, mean x and y rounded to nearest, and the duration. A run whose sample
// counter saturated gives nothing. The front sequencer steps through accept,
// squares and update for each sample, adds a push step when a step closes a run,
// and a load step before the push for a last sample that closes without a step;
// it waits only when a qualifying run finds the job queue full. The back divider
// forms one quotient bit per cycle for x and y in parallel; a two-entry queue plus
// the output register let the front keep taking samples meanwhile. Write the
// configuration port only while the block is idle.
module cursor_dwell_detector import cdd_pkg::*; #(
    parameter int COORD_BITS     = 16,
    parameter int TIME_BITS      = 31,
    parameter int RUN_COUNT_BITS = 32,
    localparam int CFG_W = (TIME_BITS > COORD_BITS) ? TIME_BITS : COORD_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    cdd_sample_if.sink       i_sample,
    cdd_result_if.source     o_result
);

    localparam int SUM_W = RUN_COUNT_BITS + COORD_BITS;
    localparam int JOB_W = 2 * TIME_BITS + RUN_COUNT_BITS + 2 * SUM_W;

    // closed runs that passed qualification, front to back
    logic             push_valid;
    logic             push_ready;
    logic [JOB_W-1:0] push_data;
    logic             pop_valid;
    logic             pop_ready;
    logic [JOB_W-1:0] pop_data;

    // Front: accept samples, split runs, accumulate, qualify closed runs
    cdd_front #(
        .TIME_BITS      (TIME_BITS),
        .COORD_BITS     (COORD_BITS),
        .RUN_COUNT_BITS (RUN_COUNT_BITS),
        .CFG_W          (CFG_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_sample     (i_sample),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    // Decouple: hold up to two closed runs while the divider is busy
    cdd_queue #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    // Back: divide sums by count, form center and duration, drive the result
    cdd_back #(
        .TIME_BITS      (TIME_BITS),
        .COORD_BITS     (COORD_BITS),
        .RUN_COUNT_BITS (RUN_COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_result    (o_result)
    );

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import cdd_pkg::*;

    // Index 3 is not mapped to any register; writes to it must be dropped.
    localparam t_cfg_idx REG_SPARE = 2'd3;
    localparam bit [30:0] TOP_MS = 31'h7FFF_FFFF;
    localparam int RANDOM_SAMPLES = 1900;
    localparam int SEGMENTS = 12;
    // Margin for the front sequencer to finish a sample that yields nothing.
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic [30:0] center;
        logic [15:0] fx;
        logic [15:0] fy;
        logic [30:0] dur;
    } t_dwell;

    // Tracks the run state of the detector and holds the dwell results that
    // are still owed by the block, oldest first.
    class dwell_scoreboard;
        localparam bit [31:0] RUN_FULL = '1;

        bit [30:0] min_ms;
        bit [30:0] max_ms;
        bit [15:0] thresh;
        bit        have_prev;
        bit [15:0] prev_x;
        bit [15:0] prev_y;
        bit [30:0] prev_t;
        bit [30:0] start_t;
        bit [31:0] n_samples;
        bit [47:0] acc_x;
        bit [47:0] acc_y;
        t_dwell    pending[$];
        int        mismatches;

        function new();
            min_ms = 31'(MIN_DWELL_RST);
            max_ms = 31'(MAX_DWELL_RST);
            thresh = 16'(MOVE_THRESH_RST);
            mismatches = 0;
            forget_run();
        endfunction

        function void forget_run();
            have_prev = 1'b0;
            prev_x = '0;
            prev_y = '0;
            prev_t = '0;
            start_t = '0;
            n_samples = '0;
            acc_x = '0;
            acc_y = '0;
        endfunction

        function void open_run(bit [30:0] t, bit [15:0] x, bit [15:0] y);
            start_t = t;
            n_samples = 1;
            acc_x = x;
            acc_y = y;
        endfunction

        function void write_reg(t_cfg_idx idx, bit [30:0] data);
            case (idx)
                REG_MIN_DWELL:   min_ms = data;
                REG_MAX_DWELL:   max_ms = data;
                REG_MOVE_THRESH: thresh = data[15:0];
                default: ;
            endcase
        endfunction

        // Close the current run at end_t; queue a dwell if the run qualifies.
        function bit close_at(bit [30:0] end_t);
            bit [63:0] s;
            bit [63:0] e;
            bit [63:0] dur;
            bit [63:0] mid;
            bit [63:0] mx;
            bit [63:0] my;
            t_dwell d;
            if (n_samples < 2 || n_samples == RUN_FULL) return 1'b0;
            if (end_t < start_t) return 1'b0;
            s = start_t;
            e = end_t;
            dur = e - s;
            if (dur < min_ms || dur > max_ms) return 1'b0;
            mid = (s >> 1) + (e >> 1) + (((s & 64'd1) + (e & 64'd1) + 64'd1) >> 1);
            mx = ({16'd0, acc_x} + (n_samples >> 1)) / n_samples;
            my = ({16'd0, acc_y} + (n_samples >> 1)) / n_samples;
            d.center = mid[30:0];
            d.fx = mx[15:0];
            d.fy = my[15:0];
            d.dur = dur[30:0];
            pending = {pending, d};
            return 1'b1;
        endfunction

        function void note_sample(bit [30:0] t, bit [15:0] x, bit [15:0] y, bit last);
            bit [63:0] dx;
            bit [63:0] dy;
            bit [63:0] d2;
            bit [63:0] th2;
            bit        made;
            made = 1'b0;
            if (!have_prev) begin
                open_run(t, x, y);
            end else begin
                dx = (x >= prev_x) ? x - prev_x : prev_x - x;
                dy = (y >= prev_y) ? y - prev_y : prev_y - y;
                d2 = dx * dx + dy * dy;
                th2 = thresh;
                th2 = th2 * th2;
                if (d2 > th2) begin
                    made = close_at(prev_t);
                    open_run(t, x, y);
                end else if (n_samples != RUN_FULL) begin
                    n_samples++;
                    if (n_samples != RUN_FULL) begin
                        acc_x += x;
                        acc_y += y;
                    end
                end
            end
            have_prev = 1'b1;
            prev_x = x;
            prev_y = y;
            prev_t = t;
            if (last) begin
                if (!made) made = close_at(t);
                forget_run();
            end
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [30:0] center, logic [15:0] fx, logic [15:0] fy,
                                   logic [30:0] dur);
            t_dwell want;
            if (pending.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got center %0d x %0d y %0d dur %0d",
                         $time, center, fx, fy, dur);
                return;
            end
            want = pending.pop_front();
            check_field("center_time_ms", want.center, center);
            check_field("focus_x", want.fx, fx);
            check_field("focus_y", want.fy, fy);
            check_field("dwell_duration_ms", want.dur, dur);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    t_cfg_idx    cfg_idx;
    logic [30:0] cfg_data;

    cdd_sample_if smp ();
    cdd_result_if res ();

    dwell_scoreboard sb = new();

    int send_idle;      // percent chance the sender holds off again before sending
    int recv_stall;     // percent chance the receiver drops ready in a cycle
    int samples_sent;

    cursor_dwell_detector i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_sample   (smp),
        .o_result   (res)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs or drops a result.
    initial begin
        #(10_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: check every transfer against the oldest owed dwell, then
    // pick ready for the next edge. Values read here are the pre-edge ones.
    always @(posedge clk) begin
        if (rst_n && res.valid && res.ready)
            sb.check_result(res.center_time_ms, res.focus_x, res.focus_y,
                            res.dwell_duration_ms);
        res.ready <= ($urandom_range(99) >= recv_stall);
    end

    // Drive one sample and hold it until the block takes it. Valid is never
    // lowered between back-to-back transfers.
    task automatic send_sample(input bit [30:0] t, input bit [15:0] x, input bit [15:0] y,
                               input bit last);
        while ($urandom_range(99) < send_idle) begin
            smp.valid <= 1'b0;
            @(posedge clk);
        end
        smp.valid       <= 1'b1;
        smp.time_ms     <= t;
        smp.pos_x       <= x;
        smp.pos_y       <= y;
        smp.last_sample <= last;
        @(posedge clk);
        while (!smp.ready) @(posedge clk);
        sb.note_sample(t, x, y, last);
        samples_sent++;
    endtask

    // Stop sending and wait until every owed dwell has come out, then let the
    // front sequencer finish whatever sample produced nothing.
    task automatic wait_idle();
        smp.valid <= 1'b0;
        do @(posedge clk); while (sb.pending.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input bit [30:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    // Reprogram all registers on an idle block. Upper bits of the threshold
    // word are junk and must be ignored.
    task automatic program_regs(input bit [30:0] lo, input bit [30:0] hi,
                                input bit [15:0] thr, input bit poke_spare);
        bit [30:0] thr_word;
        thr_word = 31'($urandom);
        thr_word[15:0] = thr;
        wait_idle();
        write_reg(REG_MIN_DWELL, lo);
        write_reg(REG_MAX_DWELL, hi);
        write_reg(REG_MOVE_THRESH, thr_word);
        if (poke_spare) write_reg(REG_SPARE, 31'($urandom));
        cfg_we <= 1'b0;
    endtask

    function automatic bit [15:0] wobble(input bit [15:0] c, input int j);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * j)) - j;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    // One cursor stream: samples jitter around a focus point, the focus
    // occasionally jumps, time advances by small random steps.
    task automatic send_stream(input int len, input int jitter, input int stepmax,
                               input bit close);
        bit [30:0] t;
        bit [15:0] cx;
        bit [15:0] cy;
        int k;
        t = 31'($urandom_range(0, 31'h7FF0_0000));
        cx = 16'($urandom);
        cy = 16'($urandom);
        for (k = 0; k < len; k++) begin
            if ($urandom_range(99) < 5) begin
                cx = 16'($urandom);
                cy = 16'($urandom);
            end
            send_sample(t, wobble(cx, jitter), wobble(cy, jitter), close && k == len - 1);
            t = 31'(t + $urandom_range(0, stepmax));
        end
    endtask

    // Fully random samples: time jumps both ways, positions anywhere.
    task automatic send_noise();
        int k;
        int n;
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
            send_sample(31'($urandom), 16'($urandom), 16'($urandom),
                        $urandom_range(9) == 0);
    endtask

    initial begin
        int mode;
        int seg;
        int plan;
        int base;
        int goal;
        int len;
        int jitter;
        int stepmax;
        bit [30:0] lo;
        bit [30:0] hi;
        bit [15:0] thr;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = REG_MIN_DWELL;
        cfg_data        = '0;
        smp.valid       = 1'b0;
        smp.time_ms     = '0;
        smp.pos_x       = '0;
        smp.pos_y       = '0;
        smp.last_sample = 1'b0;
        send_idle       = 0;
        recv_stall      = 0;
        samples_sent    = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset register values (300..3000 ms, threshold 1311).
        // Lone sample flushed by last: one-sample run, nothing.
        send_sample(0, 0, 0, 1'b1);
        // Duration exactly at the minimum; means tie and round up to 1.
        send_sample(100, 0, 1, 1'b0);
        send_sample(400, 1, 0, 1'b1);
        // Duration 2999 with odd start, even end: center rounds half up.
        send_sample(1001, 16'hFFFF, 16'hFFFF, 1'b0);
        send_sample(4000, 16'hFFFF, 16'hFFFE, 1'b1);
        // Duration one past the maximum: dropped.
        send_sample(5000, 200, 200, 1'b0);
        send_sample(8001, 200, 200, 1'b1);
        // Break and last together: old run reports, new one-sample run drops.
        send_sample(10, 1000, 1000, 1'b0);
        send_sample(400, 1000, 1000, 1'b0);
        send_sample(500, 60000, 5000, 1'b1);
        // Time going backwards: dropped.
        send_sample(2000, 500, 500, 1'b0);
        send_sample(1000, 500, 500, 1'b1);
        // Top of the time range.
        send_sample(TOP_MS - 31'd500, 32768, 32768, 1'b0);
        send_sample(TOP_MS, 32768, 32769, 1'b1);
        // Step exactly at the threshold stays in the run; one unit more breaks it.
        send_sample(0, 0, 0, 1'b0);
        send_sample(300, 1311, 0, 1'b0);
        send_sample(600, 1311, 1312, 1'b1);

        base = samples_sent;
        for (mode = 0; mode < 3; mode++) begin
            send_idle  = (mode == 0) ? 6 : (mode == 1) ? 70 : 0;
            recv_stall = (mode == 0) ? 70 : (mode == 1) ? 6 : 0;
            for (seg = 0; seg < SEGMENTS / 3; seg++) begin
                plan = mode * (SEGMENTS / 3) + seg;
                lo  = 31'($urandom_range(0, 800));
                hi  = 31'(lo + $urandom_range(0, 3000));
                thr = 16'($urandom_range(50, 4000));
                case (plan)
                    0: begin lo = 0; hi = TOP_MS; thr = 16'd0; end
                    1: begin lo = 0; hi = TOP_MS; thr = 16'hFFFF; end
                    5: begin lo = 5000; hi = 100; end
                    6: hi = lo;
                    default: ;
                endcase
                program_regs(lo, hi, thr, plan == 1 || plan == 9);

                jitter = int'(thr) / 4;
                goal = base + (plan + 1) * RANDOM_SAMPLES / SEGMENTS;
                while (samples_sent < goal) begin
                    if ($urandom_range(99) < 85) begin
                        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40)
                                                       : $urandom_range(2, 12);
                        stepmax = ((lo > 20000 ? 20000 : lo) + (hi > 20000 ? 20000 : hi))
                                  / len + 1;
                        send_stream(len, jitter, stepmax, $urandom_range(9) != 0);
                    end else begin
                        send_noise();
                    end
                end
            end
        end

        // Drain and leave room for anything the block still emits by mistake.
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
